// File: rtl/ubk_pkg.sv
// Shared constants, types and the usage-to-scan-code ROM of the boot keyboard translator.
package ubk_pkg;

    localparam int NUM_USAGES       = 232;
    localparam int MAX_REPORT_BYTES = 8;
    localparam int NUM_KEYS         = 6;
    localparam int IDX_W            = $clog2(NUM_USAGES);
    localparam int LEN_W            = 4;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_USAGES - 1);
    localparam logic [7:0]       MOD_BASE  = 8'hE0;
    localparam logic [7:0]       PREFIX_E0 = 8'hE0;
    localparam logic [7:0]       BREAK_BIT = 8'h80;
    localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_REPORT_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PFX,
        S_CODE,
        S_FLUSH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;      // latch report, read usage 0
        logic check;      // write back the held bit, latch release flag
        logic advance;    // step to next usage and read it
        logic push_pfx;   // queue the 0xE0 prefix byte
        logic push_code;  // queue make or break byte
        logic flush;      // release the queued byte as the final one
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic len_ok;     // incoming report long enough to process
        logic diff;       // held bit differs from current press state
        logic mapped;     // usage has a scan code
        logic prefix;     // scan code needs 0xE0
        logic at_last;    // scan index on final usage
        logic push_ok;    // a byte may be queued this cycle
        logic hold_vld;   // a byte waits in the hold register
        logic out_free;   // output register can take a byte
    } t_sts;

    // Bit 8: needs 0xE0 prefix. Low byte: make code. Zero: unmapped.
    function automatic logic [8:0] code_rom(input logic [7:0] u);
        logic [8:0] c;
        c = 9'h000;
        unique case (u)
            8'h04: c = 9'h01E;  8'h05: c = 9'h030;  8'h06: c = 9'h02E;  8'h07: c = 9'h020;
            8'h08: c = 9'h012;  8'h09: c = 9'h021;  8'h0A: c = 9'h022;  8'h0B: c = 9'h023;
            8'h0C: c = 9'h017;  8'h0D: c = 9'h024;  8'h0E: c = 9'h025;  8'h0F: c = 9'h026;
            8'h10: c = 9'h032;  8'h11: c = 9'h031;  8'h12: c = 9'h018;  8'h13: c = 9'h019;
            8'h14: c = 9'h010;  8'h15: c = 9'h013;  8'h16: c = 9'h01F;  8'h17: c = 9'h014;
            8'h18: c = 9'h016;  8'h19: c = 9'h02F;  8'h1A: c = 9'h011;  8'h1B: c = 9'h02D;
            8'h1C: c = 9'h015;  8'h1D: c = 9'h02C;
            8'h1E: c = 9'h002;  8'h1F: c = 9'h003;  8'h20: c = 9'h004;  8'h21: c = 9'h005;
            8'h22: c = 9'h006;  8'h23: c = 9'h007;  8'h24: c = 9'h008;  8'h25: c = 9'h009;
            8'h26: c = 9'h00A;  8'h27: c = 9'h00B;
            8'h28: c = 9'h01C;  8'h29: c = 9'h001;  8'h2A: c = 9'h00E;  8'h2B: c = 9'h00F;
            8'h2C: c = 9'h039;  8'h2D: c = 9'h00C;  8'h2E: c = 9'h00D;  8'h2F: c = 9'h01A;
            8'h30: c = 9'h01B;  8'h31: c = 9'h02B;
            8'h33: c = 9'h027;  8'h34: c = 9'h028;  8'h35: c = 9'h029;  8'h36: c = 9'h033;
            8'h37: c = 9'h034;  8'h38: c = 9'h035;  8'h39: c = 9'h03A;
            8'h3A: c = 9'h03B;  8'h3B: c = 9'h03C;  8'h3C: c = 9'h03D;  8'h3D: c = 9'h03E;
            8'h3E: c = 9'h03F;  8'h3F: c = 9'h040;  8'h40: c = 9'h041;  8'h41: c = 9'h042;
            8'h42: c = 9'h043;  8'h43: c = 9'h044;  8'h44: c = 9'h057;  8'h45: c = 9'h058;
            8'h47: c = 9'h046;
            8'h49: c = 9'h152;  8'h4A: c = 9'h147;  8'h4B: c = 9'h149;  8'h4C: c = 9'h153;
            8'h4D: c = 9'h14F;  8'h4E: c = 9'h151;  8'h4F: c = 9'h14D;  8'h50: c = 9'h14B;
            8'h51: c = 9'h150;  8'h52: c = 9'h148;
            8'h53: c = 9'h045;  8'h54: c = 9'h135;  8'h55: c = 9'h037;  8'h56: c = 9'h04A;
            8'h57: c = 9'h04E;  8'h58: c = 9'h11C;
            8'h59: c = 9'h04F;  8'h5A: c = 9'h050;  8'h5B: c = 9'h051;  8'h5C: c = 9'h04B;
            8'h5D: c = 9'h04C;  8'h5E: c = 9'h04D;  8'h5F: c = 9'h047;  8'h60: c = 9'h048;
            8'h61: c = 9'h049;  8'h62: c = 9'h052;  8'h63: c = 9'h053;
            8'h65: c = 9'h15D;
            8'hE0: c = 9'h01D;  8'hE1: c = 9'h02A;  8'hE2: c = 9'h038;  8'hE3: c = 9'h15B;
            8'hE4: c = 9'h11D;  8'hE5: c = 9'h036;  8'hE6: c = 9'h138;  8'hE7: c = 9'h15C;
            default: c = 9'h000;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/ubk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ubk_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ubk_dp.sv
// Datapath: report registers, held-key store, scan index and output byte queue.
module ubk_dp import ubk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [7:0]       i_modifiers,
    input  logic [7:0]       i_key_code_0,
    input  logic [7:0]       i_key_code_1,
    input  logic [7:0]       i_key_code_2,
    input  logic [7:0]       i_key_code_3,
    input  logic [7:0]       i_key_code_4,
    input  logic [7:0]       i_key_code_5,
    input  logic [LEN_W-1:0] i_report_length,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [7:0]       o_scancode_byte,
    output logic             o_last_byte
);

    logic [7:0]            r_mods;
    logic [7:0]            r_keys [NUM_KEYS];
    logic [NUM_KEYS-1:0]   r_key_en;
    logic [IDX_W-1:0]      r_idx;
    logic [NUM_USAGES-1:0] r_vld;
    logic                  r_rel;
    logic [7:0]            r_hold_byte;
    logic                  r_hold_vld;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    logic                  r_out_vld;

    logic [7:0]            in_keys [NUM_KEYS];
    logic [LEN_W-1:0]      len_eff;
    logic [7:0]            usage;
    logic                  pressed;
    logic                  held;
    logic                  rd_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [8:0]            code;
    logic                  out_free;
    logic [7:0]            push_byte;

    assign in_keys[0] = i_key_code_0;
    assign in_keys[1] = i_key_code_1;
    assign in_keys[2] = i_key_code_2;
    assign in_keys[3] = i_key_code_3;
    assign in_keys[4] = i_key_code_4;
    assign in_keys[5] = i_key_code_5;

    assign len_eff = (i_report_length > MAX_LEN) ? MAX_LEN : i_report_length;

    // Latch the report; a key byte counts only if it lies inside the report and is nonzero
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mods <= i_modifiers;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_keys[k]   <= in_keys[k];
                r_key_en[k] <= (LEN_W'(k + 2) < len_eff) && (in_keys[k] != 8'h00);
            end
        end
    end

    assign usage = 8'(r_idx);

    always_comb begin
        pressed = (usage >= MOD_BASE) && r_mods[usage[2:0]];
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (r_key_en[k] && (r_keys[k] == usage)) begin
                pressed = 1'b1;
            end
        end
    end

    // Never-written entries read as released
    assign held    = r_vld[r_idx] && rd_data;
    assign rd_addr = i_cmd.start ? '0 : r_idx + IDX_W'(1);

    ubk_ram #(
        .WIDTH (1),
        .DEPTH (NUM_USAGES)
    ) u_held (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.check),
        .i_wr_addr (r_idx),
        .i_wr_data (pressed),
        .i_rd_en   (i_cmd.start || i_cmd.advance),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.check) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.check) begin
            r_rel <= held;
        end
    end

    assign code      = code_rom(usage);
    assign out_free  = !r_out_vld || !i_stall;
    assign push_byte = i_cmd.push_pfx ? PREFIX_E0 : (code[7:0] | (r_rel ? BREAK_BIT : 8'h00));

    // One byte waits in hold so the last one can be marked when the scan ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.push_pfx || i_cmd.push_code) begin
                r_hold_vld <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_vld <= 1'b0;
            end
            if (((i_cmd.push_pfx || i_cmd.push_code || i_cmd.flush) && r_hold_vld)) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_pfx || i_cmd.push_code) begin
            r_hold_byte <= push_byte;
        end
        if ((i_cmd.push_pfx || i_cmd.push_code || i_cmd.flush) && r_hold_vld) begin
            r_out_byte <= r_hold_byte;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_scancode_byte = r_out_byte;
    assign o_last_byte     = r_out_last;

    always_comb begin
        o_sts          = '0;
        o_sts.len_ok   = (i_report_length >= MIN_LEN);
        o_sts.diff     = (held != pressed);
        o_sts.mapped   = (code != 9'h000);
        o_sts.prefix   = code[8];
        o_sts.at_last  = (r_idx == LAST_IDX);
        o_sts.push_ok  = !r_hold_vld || out_free;
        o_sts.hold_vld = r_hold_vld;
        o_sts.out_free = out_free;
    end

endmodule

// File: rtl/ubk_ctrl.sv
// Controller: sequences the usage scan and the byte emission.
module ubk_ctrl import ubk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_busy,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // Short reports are taken and dropped
                if (i_valid && i_sts.len_ok) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.diff && i_sts.mapped) begin
                    n_state = i_sts.prefix ? S_PFX : S_CODE;
                end else if (i_sts.at_last) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_PFX: begin
                if (i_sts.push_ok) begin
                    o_cmd.push_pfx = 1'b1;
                    n_state        = S_CODE;
                end
            end
            S_CODE: begin
                if (i_sts.push_ok) begin
                    o_cmd.push_code = 1'b1;
                    if (i_sts.at_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_CHECK;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.hold_vld) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_state = r_state;

endmodule

// File: rtl/usb_boot_keyboard_to_ps2_scancode_core.sv
// Top level: USB boot-keyboard report to PS/2 scan code set 1 translator.
// Each accepted report (modifier byte, six key usages, report length) is compared
// against a held bit per usage; the block walks usages 0 to 231 in ascending order
// and emits a set-1 make code for every new press and a break code (make | 0x80)
// for every release, with an 0xE0 prefix where the code table asks for it. Usages
// without a code update their held bit silently. Reports shorter than two bytes are
// taken and dropped; lengths above eight count as eight. The held bits live in a
// 232 x 1 RAM with a registered read, read one usage per cycle while no byte is
// being emitted; a valid flop per usage, cleared at reset, makes a never-written
// entry read as released, so no clearing pass is needed. The input stalls while a
// report is being scanned. Output bytes leave through a one-entry hold stage and
// an output register, so the final byte of a report is flagged with o_last_byte
// and a finished transaction can wait on the output while the next report is
// taken.
module usb_boot_keyboard_to_ps2_scancode_core import ubk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_modifiers,
    input  logic [7:0]       i_key_code_0,
    input  logic [7:0]       i_key_code_1,
    input  logic [7:0]       i_key_code_2,
    input  logic [7:0]       i_key_code_3,
    input  logic [7:0]       i_key_code_4,
    input  logic [7:0]       i_key_code_5,
    input  logic [LEN_W-1:0] i_report_length,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_scancode_byte,
    output logic             o_last_byte
);

    t_cmd   cmd;
    t_sts   sts;
    t_state state;
    logic   busy;

    ubk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_state (state)
    );

    ubk_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_modifiers     (i_modifiers),
        .i_key_code_0    (i_key_code_0),
        .i_key_code_1    (i_key_code_1),
        .i_key_code_2    (i_key_code_2),
        .i_key_code_3    (i_key_code_3),
        .i_key_code_4    (i_key_code_4),
        .i_key_code_5    (i_key_code_5),
        .i_report_length (i_report_length),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_scancode_byte (o_scancode_byte),
        .o_last_byte     (o_last_byte)
    );

    // Hold off new reports for the whole scan
    assign o_stall = busy;

    // Ready for a report means the previous one left nothing in the hold stage
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !sts.hold_vld)
        else $error("report accepted with a byte still queued");

    // Queue a byte only when it cannot overwrite an untaken one
    a_push_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.push_pfx || cmd.push_code) |-> sts.push_ok)
        else $error("byte queued over a pending byte");

    // A prefix byte is always followed by its code byte before the scan moves on
    a_pfx_then_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push_pfx |=> (state == S_CODE))
        else $error("prefix not followed by code");

    // Final byte goes out only into a free output register
    a_flush_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |-> (sts.out_free && sts.hold_vld))
        else $error("final byte released while output busy");

endmodule
